// File: sv/sdq_pkg.sv
// ----------------------------------------------------------------------------
// Sleep delta queue package
// Shared widths, codes, the stored entry layout and the sequencer states.
// ----------------------------------------------------------------------------
package sdq_pkg;

  localparam int TASK_W        = 8;
  localparam int DELTA_W       = 31;
  localparam int KIND_W        = 2;
  localparam int DEPTH_DEFAULT = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int REL_W         = $clog2(MAX_RESULTS + 1);

  typedef enum logic [0:0] {
    FUNC_TICK   = 1'b0,
    FUNC_INSERT = 1'b1
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPT  = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [TASK_W-1:0]  task_id;
    logic [DELTA_W-1:0] delta;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIX,
    ST_EMIT,
    ST_TICK_HEAD,
    ST_TICK_NEXT
  } state_t;

endpackage

// File: sv/sdq_in_if.sv
// ----------------------------------------------------------------------------
// Sleep delta queue input channel
// Valid/ready channel carrying one tick or insert request.
// ----------------------------------------------------------------------------
interface sdq_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [sdq_pkg::TASK_W-1:0]  task_id;
  logic [sdq_pkg::DELTA_W-1:0] duration;

  modport source (output valid, output func, output task_id, output duration, input ready);
  modport sink (input valid, input func, input task_id, input duration, output ready);
endinterface

// File: sv/sdq_out_if.sv
// ----------------------------------------------------------------------------
// Sleep delta queue result channel
// Valid/ready channel carrying one result request.
// ----------------------------------------------------------------------------
interface sdq_out_if;
  logic                      valid;
  logic                      ready;
  logic [sdq_pkg::KIND_W-1:0] kind;
  logic [sdq_pkg::TASK_W-1:0] task_id_res;
  logic                      last;

  modport source (output valid, output kind, output task_id_res, output last, input ready);
  modport sink (input valid, input kind, input task_id_res, input last, output ready);
endinterface

// File: sv/sdq_ram.sv
// ----------------------------------------------------------------------------
// Sleep delta queue RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module sdq_ram #(
  parameter int WIDTH = 39,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/sleep_delta_queue_top.sv
// ----------------------------------------------------------------------------
// Sleep delta queue
// Delta list of sleeping tasks held as a circular buffer in one RAM.
// ----------------------------------------------------------------------------
// A request on in_req is either a tick or an insert of task_id with a sleep
// duration. Results leave on out_res; every request that causes results ends
// its run of results with last set.
// An insert walks the list from the head, one stored entry per cycle, through
// a single shared subtractor; each entry passed over moves one slot towards
// the head, so the new task drops into the freed slot and the head pointer
// steps back. An insert that goes at the tail writes the new entry and moves
// on to its result; otherwise a fix step first takes the new delta off its
// successor. A full store goes straight to its result. The next request can
// be taken in the cycle the result is presented.
// A tick reads the head, then releases one task per cycle while the head
// delta is zero and the receiver does not stall, at most sixteen per tick.
// A new request is taken only in the idle state. Results are held in an output
// register; when the receiver stalls the sequencer waits at its next result.
// Reset empties the list at once; stored entries need no clearing.
// ----------------------------------------------------------------------------
module sleep_delta_queue_top #(
  parameter int DEPTH = sdq_pkg::DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  sdq_in_if.sink     in_req,
  sdq_out_if.source  out_res
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = sdq_pkg::DELTA_W;
  localparam int RW = sdq_pkg::REL_W;

  sdq_pkg::state_t state, state_next;
  logic [IW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] ptr, ptr_next;
  logic [CW-1:0] k, k_next;
  logic [DW-1:0] rem, rem_next;
  logic [RW-1:0] n_rel, n_rel_next;
  logic [sdq_pkg::TASK_W-1:0] task_r, task_r_next;
  logic [sdq_pkg::TASK_W-1:0] pend, pend_next;
  sdq_pkg::kind_t kind_r, kind_r_next;

  logic out_valid;
  sdq_pkg::kind_t out_kind;
  logic [sdq_pkg::TASK_W-1:0] out_task;
  logic out_last;
  logic out_load;
  sdq_pkg::kind_t load_kind;
  logic [sdq_pkg::TASK_W-1:0] load_task;
  logic load_last;
  logic slot_free;

  logic wen;
  logic [IW-1:0] waddr, raddr;
  sdq_pkg::entry_t wdata, rdata;

  logic [DW-1:0] sub_a, sub_b;
  logic [DW:0] sub_res;
  logic borrow;
  logic more;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x);
    return (x == IW'(DEPTH - 1)) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] x);
    return (x == '0) ? IW'(DEPTH - 1) : x - 1'b1;
  endfunction

  sdq_ram #(
    .WIDTH ($bits(sdq_pkg::entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .wen   (wen),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sub_res   = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow    = sub_res[DW];
  assign slot_free = !out_valid || out_res.ready;
  assign more      = (count != '0) && (rdata.delta == '0) &&
                     (n_rel < RW'(sdq_pkg::MAX_RESULTS));

  assign in_req.ready       = (state == sdq_pkg::ST_IDLE);
  assign out_res.valid      = out_valid;
  assign out_res.kind       = out_kind;
  assign out_res.task_id_res = out_task;
  assign out_res.last       = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sdq_pkg::ST_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr    <= ptr_next;
    k      <= k_next;
    rem    <= rem_next;
    n_rel  <= n_rel_next;
    task_r <= task_r_next;
    pend   <= pend_next;
    kind_r <= kind_r_next;
    if (out_load) begin
      out_kind <= load_kind;
      out_task <= load_task;
      out_last <= load_last;
    end
  end

  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    ptr_next    = ptr;
    k_next      = k;
    rem_next    = rem;
    n_rel_next  = n_rel;
    task_r_next = task_r;
    pend_next   = pend;
    kind_r_next = kind_r;
    out_load    = 1'b0;
    load_kind   = kind_r;
    load_task   = task_r;
    load_last   = 1'b1;
    wen         = 1'b0;
    waddr       = ptr;
    wdata       = rdata;
    raddr       = head;
    sub_a       = rem;
    sub_b       = rdata.delta;

    case (state)
      sdq_pkg::ST_IDLE: begin
        if (in_req.valid) begin
          if (in_req.func == sdq_pkg::FUNC_INSERT) begin
            task_r_next = in_req.task_id;
            rem_next    = in_req.duration;
            ptr_next    = head;
            k_next      = '0;
            if (count == CW'(DEPTH)) begin
              kind_r_next = sdq_pkg::KIND_FULL;
              state_next  = sdq_pkg::ST_EMIT;
            end else begin
              kind_r_next = sdq_pkg::KIND_ACCEPT;
              state_next  = sdq_pkg::ST_WALK;
            end
          end else if (count != '0) begin
            n_rel_next = '0;
            state_next = sdq_pkg::ST_TICK_HEAD;
          end
        end
      end

      sdq_pkg::ST_WALK: begin
        raddr = ptr;
        if ((k == count) || borrow) begin
          wen           = 1'b1;
          waddr         = idx_dec(ptr);
          wdata.task_id = task_r;
          wdata.delta   = rem;
          if (k == count) begin
            head_next  = idx_dec(head);
            count_next = count + 1'b1;
            state_next = sdq_pkg::ST_EMIT;
          end else begin
            state_next = sdq_pkg::ST_FIX;
          end
        end else begin
          wen      = 1'b1;
          waddr    = idx_dec(ptr);
          rem_next = sub_res[DW-1:0];
          ptr_next = idx_inc(ptr);
          k_next   = k + 1'b1;
          raddr    = idx_inc(ptr);
        end
      end

      sdq_pkg::ST_FIX: begin
        raddr       = ptr;
        sub_a       = rdata.delta;
        sub_b       = rem;
        wen         = 1'b1;
        waddr       = ptr;
        wdata.delta = sub_res[DW-1:0];
        head_next   = idx_dec(head);
        count_next  = count + 1'b1;
        state_next  = sdq_pkg::ST_EMIT;
      end

      sdq_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = sdq_pkg::ST_IDLE;
        end
      end

      sdq_pkg::ST_TICK_HEAD: begin
        sub_a = rdata.delta;
        sub_b = DW'(1);
        if (rdata.delta[DW-1:1] == '0) begin
          pend_next  = rdata.task_id;
          head_next  = idx_inc(head);
          count_next = count - 1'b1;
          n_rel_next = RW'(1);
          raddr      = idx_inc(head);
          state_next = sdq_pkg::ST_TICK_NEXT;
        end else begin
          wen         = 1'b1;
          waddr       = head;
          wdata.delta = sub_res[DW-1:0];
          state_next  = sdq_pkg::ST_IDLE;
        end
      end

      sdq_pkg::ST_TICK_NEXT: begin
        if (slot_free) begin
          out_load  = 1'b1;
          load_kind = sdq_pkg::KIND_RELEASE;
          load_task = pend;
          load_last = !more;
          if (more) begin
            pend_next  = rdata.task_id;
            head_next  = idx_inc(head);
            count_next = count - 1'b1;
            n_rel_next = n_rel + 1'b1;
            raddr      = idx_inc(head);
          end else begin
            state_next = sdq_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_next = sdq_pkg::ST_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("Entry count exceeds the store depth.");

  a_fix_grows: assert property (@(posedge clk) disable iff (rst)
    state == sdq_pkg::ST_FIX |=> count == $past(count) + 1'b1)
    else $error("Insert with a successor did not grow the list by one.");

  a_release_bound: assert property (@(posedge clk) disable iff (rst)
    state == sdq_pkg::ST_TICK_NEXT |-> n_rel <= RW'(sdq_pkg::MAX_RESULTS))
    else $error("Too many releases on one tick.");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == sdq_pkg::ST_IDLE || state == sdq_pkg::ST_EMIT) |-> !wen)
    else $error("RAM written outside an active sequence.");

  a_full_only: assert property (@(posedge clk) disable iff (rst)
    (out_load && load_kind == sdq_pkg::KIND_FULL) |-> count == CW'(DEPTH))
    else $error("Insert rejected while the store had room.");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sleep delta queue testbench
// Drives tick and insert requests into the sleep delta queue and checks every
// result against a behavioural copy of the delta list kept in the testbench.
// Directed sequences cover an empty tick, a zero sleep, ordering of equal wake
// times and a full store; random sequences follow, including a long receiver
// hold-off and a stretch without idle cycles; directed very long sleeps come last.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int QUEUE_DEPTH    = sdq_pkg::DEPTH_DEFAULT;
  localparam int TW             = sdq_pkg::TASK_W;
  localparam int DW             = sdq_pkg::DELTA_W;
  localparam int STALL_LIMIT    = 3000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int HOLDOFF_CYCLES = 200;

  typedef struct packed {
    sdq_pkg::kind_t kind;
    logic [TW-1:0]  task_id;
    logic           last;
  } sched_notice_t;

  logic clk;
  logic rst;

  sdq_in_if  req_ch ();
  sdq_out_if res_ch ();

  sleep_delta_queue_top #(
    .DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .in_req  (req_ch),
    .out_res (res_ch)
  );

  logic [TW-1:0]  sleeper_task [QUEUE_DEPTH];
  logic [DW-1:0]  sleeper_delta [QUEUE_DEPTH];
  int             sleeper_count = 0;
  sched_notice_t  notice_q [$];

  int  mismatch_count = 0;
  int  notices_seen   = 0;
  int  inserts_sent   = 0;
  int  ticks_sent     = 0;
  int  rejects_due    = 0;
  int  releases_due   = 0;
  int  stall_cycles   = 0;
  int  holdoff_cycles = 0;
  bit  no_idle        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void expect_notice(input sdq_pkg::kind_t kind,
                                        input logic [TW-1:0] tid, input logic last);
    sched_notice_t n;
    n.kind    = kind;
    n.task_id = tid;
    n.last    = last;
    notice_q.insert(notice_q.size(), n);
  endfunction

  // Applies one accepted request to the delta list and queues the notices it causes.
  function automatic void apply_to_sleep_list(input sdq_pkg::func_t fn,
                                              input logic [TW-1:0] tid,
                                              input logic [DW-1:0] dur);
    int            pos;
    int            i;
    int            released;
    logic          is_last;
    logic [DW-1:0] rem;
    if (fn == sdq_pkg::FUNC_INSERT) begin
      if (sleeper_count >= QUEUE_DEPTH) begin
        expect_notice(sdq_pkg::KIND_FULL, tid, 1'b1);
        rejects_due++;
        return;
      end
      pos = 0;
      rem = dur;
      while (pos < sleeper_count && rem >= sleeper_delta[pos]) begin
        rem = rem - sleeper_delta[pos];
        pos++;
      end
      for (i = sleeper_count; i > pos; i--) begin
        sleeper_task[i]  = sleeper_task[i-1];
        sleeper_delta[i] = sleeper_delta[i-1];
      end
      sleeper_task[pos]  = tid;
      sleeper_delta[pos] = rem;
      if (pos < sleeper_count) begin
        sleeper_delta[pos+1] = sleeper_delta[pos+1] - rem;
      end
      sleeper_count++;
      expect_notice(sdq_pkg::KIND_ACCEPT, tid, 1'b1);
    end else begin
      if (sleeper_count == 0) begin
        return;
      end
      if (sleeper_delta[0] != '0) begin
        sleeper_delta[0] = sleeper_delta[0] - 1'b1;
      end
      released = 0;
      while (sleeper_count > 0 && sleeper_delta[0] == '0 &&
             released < sdq_pkg::MAX_RESULTS) begin
        is_last = (released + 1 == sdq_pkg::MAX_RESULTS) || (sleeper_count == 1) ||
                  (sleeper_delta[1] != '0);
        expect_notice(sdq_pkg::KIND_RELEASE, sleeper_task[0], is_last);
        for (i = 1; i < sleeper_count; i++) begin
          sleeper_task[i-1]  = sleeper_task[i];
          sleeper_delta[i-1] = sleeper_delta[i];
        end
        sleeper_count--;
        released++;
        releases_due++;
      end
    end
  endfunction

  task automatic send_request(input sdq_pkg::func_t fn, input logic [TW-1:0] tid,
                              input logic [DW-1:0] dur);
    while (!no_idle && holdoff_cycles == 0 && $urandom_range(0, 99) < 30) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid    <= 1'b1;
    req_ch.func     <= fn;
    req_ch.task_id  <= tid;
    req_ch.duration <= dur;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    apply_to_sleep_list(fn, tid, dur);
    if (fn == sdq_pkg::FUNC_INSERT) begin
      inserts_sent++;
    end else begin
      ticks_sent++;
    end
  endtask

  task automatic send_random_request();
    logic [TW-1:0]   tid;
    logic [DW-1:0]   dur;
    int              pick;
    sdq_pkg::func_t  fn;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      dur = DW'($urandom_range(0, 4));
    end else if (pick < 95) begin
      dur = DW'($urandom_range(5, 40));
    end else begin
      dur = DW'($urandom() >> 1);
    end
    tid = TW'($urandom_range(0, 255));
    fn  = ($urandom_range(0, 1) == 1) ? sdq_pkg::FUNC_INSERT : sdq_pkg::FUNC_TICK;
    send_request(fn, tid, dur);
  endtask

  task automatic test_empty_tick();
    send_request(sdq_pkg::FUNC_TICK, 8'h00, '0);
  endtask

  // A zero sleep leaves a zero head delta, which the next tick releases without wrapping.
  task automatic test_zero_duration();
    send_request(sdq_pkg::FUNC_INSERT, 8'h00, '0);
    send_request(sdq_pkg::FUNC_TICK, 8'h00, '0);
  endtask

  // Equal wake times keep arrival order; an earlier sleeper shortens its successor.
  task automatic test_equal_wake_order();
    send_request(sdq_pkg::FUNC_INSERT, 8'hFF, 31'd3);
    send_request(sdq_pkg::FUNC_INSERT, 8'h55, 31'd2);
    send_request(sdq_pkg::FUNC_INSERT, 8'hAA, 31'd3);
    repeat (3) send_request(sdq_pkg::FUNC_TICK, 8'h00, '0);
  endtask

  task automatic test_full_store();
    int i;
    for (i = 0; i < QUEUE_DEPTH; i++) begin
      send_request(sdq_pkg::FUNC_INSERT, TW'(i * 17), 31'd1);
    end
    send_request(sdq_pkg::FUNC_INSERT, 8'h5A, 31'd0);
    send_request(sdq_pkg::FUNC_TICK, 8'h00, '0);
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_random_request();
  endtask

  // The receiver holds off while requests keep coming, so the block must stall its input.
  task automatic test_receiver_holdoff(input int count);
    holdoff_cycles = HOLDOFF_CYCLES;
    repeat (count) send_random_request();
  endtask

  task automatic test_no_idle_burst(input int count);
    no_idle = 1'b1;
    repeat (count) send_random_request();
    no_idle = 1'b0;
  endtask

  task automatic test_long_sleeps();
    send_request(sdq_pkg::FUNC_INSERT, 8'h81, 31'h7FFF_FFFF);
    send_request(sdq_pkg::FUNC_INSERT, 8'h7E, 31'h2AAA_AAAA);
    send_request(sdq_pkg::FUNC_INSERT, 8'h3C, 31'h5555_5555);
    send_request(sdq_pkg::FUNC_TICK, 8'h00, '0);
  endtask

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_cycles > 0) begin
        res_ch.ready <= 1'b0;
        holdoff_cycles--;
      end else if (no_idle) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= 30);
      end
    end
  end

  always @(posedge clk) begin : check_notices
    sched_notice_t exp_n;
    if (!rst && res_ch.valid && res_ch.ready) begin
      notices_seen++;
      if (notice_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d task %0d last %0d",
                 $time, res_ch.kind, res_ch.task_id_res, res_ch.last);
        mismatch_count++;
      end else begin
        exp_n = notice_q[0];
        notice_q.delete(0);
        if (res_ch.kind !== exp_n.kind) begin
          $display("%0t: kind mismatch, expected %0d, actual %0d",
                   $time, exp_n.kind, res_ch.kind);
          mismatch_count++;
        end
        if (res_ch.task_id_res !== exp_n.task_id) begin
          $display("%0t: task mismatch, expected %0d, actual %0d",
                   $time, exp_n.task_id, res_ch.task_id_res);
          mismatch_count++;
        end
        if (res_ch.last !== exp_n.last) begin
          $display("%0t: last mismatch, expected %0d, actual %0d",
                   $time, exp_n.last, res_ch.last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, notice_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.func     = sdq_pkg::FUNC_TICK;
    req_ch.task_id  = '0;
    req_ch.duration = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_empty_tick();
    test_zero_duration();
    test_equal_wake_order();
    test_full_store();
    test_random_mix(50);
    test_receiver_holdoff(20);
    test_no_idle_burst(30);
    test_long_sleeps();

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (notice_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d inserts and %0d ticks; %0d results checked, of which %0d releases",
             inserts_sent, ticks_sent, notices_seen, releases_due);
    $display("and %0d inserts refused by a full store; %0d mismatches.",
             rejects_due, mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/sdq_pkg.sv
sv/sdq_in_if.sv
sv/sdq_out_if.sv
sv/sdq_ram.sv
sv/sleep_delta_queue_top.sv
tb/tb_top.sv
